@@ sv/cfpp_pkg.sv @@
// cfpp_pkg: shared types, constants and the crc-32 byte update for the
// framed packet parser; no dependencies
`default_nettype none

package cfpp_pkg;

    // frame markers and header layout
    localparam logic [7:0]  START_BYTE    = 8'hFE;
    localparam logic [7:0]  END_BYTE      = 8'hFD;
    localparam logic [7:0]  HEAD_LEN_POS  = 8'd1;
    localparam logic [7:0]  HEAD_CODE_POS = 8'd2;
    localparam logic [7:0]  HEAD_ID_POS   = 8'd6;
    localparam logic [7:0]  CRC_LAST_POS  = 8'd3;

    // reflected crc-32
    localparam logic [31:0] CRC_POLY      = 32'hEDB8_8320;
    localparam logic [31:0] CRC_ALL_ONES  = 32'hFFFF_FFFF;

    // state code classes
    localparam logic [7:0]  CODE_FIRST    = 8'hA0;
    localparam logic [7:0]  CODE_LAST     = 8'hA6;
    localparam logic [2:0]  CLASS_UNKNOWN = 3'd7;

    // result kinds
    localparam logic        KIND_PAYLOAD  = 1'b0;
    localparam logic        KIND_REPORT   = 1'b1;

    // frame status codes
    localparam logic [2:0]  ST_OK         = 3'd0;
    localparam logic [2:0]  ST_CRC_BAD    = 3'd1;
    localparam logic [2:0]  ST_END_BAD    = 3'd2;
    localparam logic [2:0]  ST_BAD_START  = 3'd4;

    typedef enum logic [2:0] {
        PH_HUNT  = 3'd0,
        PH_SKIP  = 3'd1,
        PH_HEAD  = 3'd2,
        PH_BODY  = 3'd3,
        PH_CHECK = 3'd4,
        PH_TAIL  = 3'd5
    } phase_t;

    // registered input byte handed to the parser core
    typedef struct packed {
        logic       valid;
        logic [7:0] data;
    } stage_t;

    // one result transaction
    typedef struct packed {
        logic        result_kind;
        logic [7:0]  payload_byte;
        logic [7:0]  payload_index;
        logic [2:0]  frame_status;
        logic [2:0]  state_class;
        logic [7:0]  state_code;
        logic [7:0]  device_id;
        logic [7:0]  payload_length;
        logic [31:0] computed_crc;
        logic [31:0] received_crc;
    } result_t;

    // one byte through the reflected crc, lsb first
    function automatic logic [31:0] crc32_byte(input logic [31:0] crc_in,
                                               input logic [7:0]  data);
        logic [31:0] crc;
        crc = crc_in ^ {24'd0, data};
        for (int k = 0; k < 8; k++)
        begin
            if (crc[0])
                crc = (crc >> 1) ^ CRC_POLY;
            else
                crc = crc >> 1;
        end
        return crc;
    endfunction

endpackage

`default_nettype wire

@@ sv/cfpp_ifs.sv @@
// cfpp_ifs: valid/ready channel interfaces for the byte stream and the
// result stream; depends on nothing
`default_nettype none

interface cfpp_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;

    modport source (output valid, output data_byte, input ready);
    modport sink   (input valid, input data_byte, output ready);
endinterface

interface cfpp_result_if;
    logic        valid;
    logic        ready;
    logic        result_kind;
    logic [7:0]  payload_byte;
    logic [7:0]  payload_index;
    logic [2:0]  frame_status;
    logic [2:0]  state_class;
    logic [7:0]  state_code;
    logic [7:0]  device_id;
    logic [7:0]  payload_length;
    logic [31:0] computed_crc;
    logic [31:0] received_crc;

    modport source (output valid, output result_kind, output payload_byte,
                    output payload_index, output frame_status, output state_class,
                    output state_code, output device_id, output payload_length,
                    output computed_crc, output received_crc, input ready);
    modport sink   (input valid, input result_kind, input payload_byte,
                    input payload_index, input frame_status, input state_class,
                    input state_code, input device_id, input payload_length,
                    input computed_crc, input received_crc, output ready);
endinterface

`default_nettype wire

@@ sv/cfpp_in_stage.sv @@
// cfpp_in_stage: input register for the byte stream
// depends on cfpp_pkg and cfpp_byte_if
`default_nettype none

module cfpp_in_stage
    import cfpp_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    cfpp_byte_if.sink    stream,
    input  wire logic    take,
    output stage_t       stage
);

    logic       valid_reg;
    logic       valid_next;
    logic [7:0] data_reg;
    logic       load;

    // room whenever empty or the core drains the held byte this cycle
    assign stream.ready = !valid_reg || take;
    assign load         = stream.valid && stream.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
            valid_next = 1'b1;
        else if (take)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    // payload register, no reset needed
    always_ff @(posedge clk)
    begin
        if (load)
            data_reg <= stream.data_byte;
    end

    assign stage.valid = valid_reg;
    assign stage.data  = data_reg;

endmodule

`default_nettype wire

@@ sv/cfpp_core.sv @@
// cfpp_core: frame state machine, crc and field capture, result register
// depends on cfpp_pkg and cfpp_result_if
`default_nettype none

module cfpp_core
    import cfpp_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  stage_t        stage,
    output logic          take,
    cfpp_result_if.source report
);

    phase_t      phase_reg, phase_next;
    logic [7:0]  pos_reg, pos_next;
    logic [7:0]  len_reg, len_next;
    logic [7:0]  code_reg, code_next;
    logic [7:0]  id_reg, id_next;
    logic [31:0] crc_reg, crc_next;
    logic [31:0] carried_reg, carried_next;

    logic        out_valid_reg, out_valid_next;
    result_t     out_reg, res;
    logic        produce;
    logic        out_free;
    logic [7:0]  b;
    logic [31:0] computed;
    logic [2:0]  cls;

    // a byte is consumed only when the result register can take its result
    assign out_free = !out_valid_reg || report.ready;
    assign take     = stage.valid && out_free;
    assign b        = stage.data;

    // report fields derived from held state
    assign computed = crc_reg ^ CRC_ALL_ONES;
    always_comb
    begin
        if (code_reg >= CODE_FIRST && code_reg <= CODE_LAST)
            cls = 3'(code_reg - CODE_FIRST);
        else
            cls = CLASS_UNKNOWN;
    end

    // next state and result
    always_comb
    begin
        phase_next   = phase_reg;
        pos_next     = pos_reg;
        len_next     = len_reg;
        code_next    = code_reg;
        id_next      = id_reg;
        crc_next     = crc_reg;
        carried_next = carried_reg;
        produce      = 1'b0;
        res          = '0;
        unique case (phase_reg) inside
            PH_HUNT, PH_SKIP:
            begin
                if (phase_reg == PH_HUNT && b == START_BYTE)
                begin
                    phase_next   = PH_HEAD;
                    pos_next     = HEAD_LEN_POS;
                    len_next     = 8'd0;
                    code_next    = 8'd0;
                    id_next      = 8'd0;
                    crc_next     = CRC_ALL_ONES;
                    carried_next = 32'd0;
                end
                else if (b == END_BYTE)
                begin
                    phase_next       = PH_HUNT;
                    pos_next         = 8'd0;
                    produce          = 1'b1;
                    res.result_kind  = KIND_REPORT;
                    res.frame_status = ST_BAD_START;
                end
                else
                begin
                    phase_next = PH_SKIP;
                end
            end
            PH_HEAD:
            begin
                if (pos_reg == HEAD_LEN_POS)
                    len_next = b;
                else if (pos_reg == HEAD_CODE_POS)
                    code_next = b;
                else if (pos_reg == HEAD_ID_POS)
                    id_next = b;
                if (pos_reg >= HEAD_ID_POS)
                begin
                    pos_next   = 8'd0;
                    phase_next = (len_reg == 8'd0) ? PH_CHECK : PH_BODY;
                end
                else
                begin
                    pos_next = pos_reg + 8'd1;
                end
            end
            PH_BODY:
            begin
                crc_next          = crc32_byte(crc_reg, b);
                produce           = 1'b1;
                res.result_kind   = KIND_PAYLOAD;
                res.payload_byte  = b;
                res.payload_index = pos_reg;
                if ({1'b0, pos_reg} + 9'd1 >= {1'b0, len_reg})
                begin
                    pos_next   = 8'd0;
                    phase_next = PH_CHECK;
                end
                else
                begin
                    pos_next = pos_reg + 8'd1;
                end
            end
            PH_CHECK:
            begin
                carried_next = {carried_reg[23:0], b};
                if (pos_reg >= CRC_LAST_POS)
                begin
                    pos_next   = 8'd0;
                    phase_next = PH_TAIL;
                end
                else
                begin
                    pos_next = pos_reg + 8'd1;
                end
            end
            PH_TAIL:
            begin
                produce            = 1'b1;
                res.result_kind    = KIND_REPORT;
                res.frame_status   = ST_OK
                                   | ((computed != carried_reg) ? ST_CRC_BAD : ST_OK)
                                   | ((b != END_BYTE) ? ST_END_BAD : ST_OK);
                res.state_class    = cls;
                res.state_code     = code_reg;
                res.device_id      = id_reg;
                res.payload_length = len_reg;
                res.computed_crc   = computed;
                res.received_crc   = carried_reg;
                phase_next         = PH_HUNT;
                pos_next           = 8'd0;
            end
            default:
            begin
                phase_next = PH_HUNT;
                pos_next   = 8'd0;
            end
        endcase
    end

    // frame state registers, advanced once per consumed byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_HUNT;
            pos_reg     <= 8'd0;
            len_reg     <= 8'd0;
            code_reg    <= 8'd0;
            id_reg      <= 8'd0;
            crc_reg     <= CRC_ALL_ONES;
            carried_reg <= 32'd0;
        end
        else if (take)
        begin
            phase_reg   <= phase_next;
            pos_reg     <= pos_next;
            len_reg     <= len_next;
            code_reg    <= code_next;
            id_reg      <= id_next;
            crc_reg     <= crc_next;
            carried_reg <= carried_next;
        end
    end

    // result register valid
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (take)
            out_valid_next = produce;
        else if (report.ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (take && produce)
            out_reg <= res;
    end

    assign report.valid          = out_valid_reg;
    assign report.result_kind    = out_reg.result_kind;
    assign report.payload_byte   = out_reg.payload_byte;
    assign report.payload_index  = out_reg.payload_index;
    assign report.frame_status   = out_reg.frame_status;
    assign report.state_class    = out_reg.state_class;
    assign report.state_code     = out_reg.state_code;
    assign report.device_id      = out_reg.device_id;
    assign report.payload_length = out_reg.payload_length;
    assign report.computed_crc   = out_reg.computed_crc;
    assign report.received_crc   = out_reg.received_crc;

    // header position stays inside the header bytes
    a_head_pos: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_HEAD |-> (pos_reg >= HEAD_LEN_POS && pos_reg <= HEAD_ID_POS))
        else $error("header position out of range");

    // payload index never reaches the frame length
    a_body_pos: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_BODY |-> pos_reg < len_reg)
        else $error("payload index beyond frame length");

    // crc byte counter stays within four bytes
    a_check_pos: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_CHECK |-> pos_reg <= CRC_LAST_POS)
        else $error("crc byte counter out of range");

    // a forwarded payload byte only comes from the body phase
    a_payload_src: assert property (@(posedge clk) disable iff (!rst_n)
        (take && produce && res.result_kind == KIND_PAYLOAD) |-> phase_reg == PH_BODY)
        else $error("payload transaction outside frame body");

endmodule

`default_nettype wire

@@ sv/crc32_framed_packet_parser.sv @@
// crc32_framed_packet_parser: top level of the framed packet parser
// depends on cfpp_pkg, cfpp_ifs, cfpp_in_stage and cfpp_core
//
//   channel   dir   handshake      payload
//   stream    in    valid/ready    data_byte (8)
//   report    out   valid/ready    result_kind .. received_crc (one transaction)
//
// one byte is taken per cycle while the report is not stalled; a result is presented
// after its byte has passed the input register and then the result register
// the core consumes a byte only when the result register is free or drains
// in the same cycle, so a stalled report holds the input register full
// reset clears the frame state to hunting and empties both registers
`default_nettype none

module crc32_framed_packet_parser
    import cfpp_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    cfpp_byte_if.sink     stream,
    cfpp_result_if.source report
);

    stage_t stage;
    logic   take;

    cfpp_in_stage u_in_stage (
        .clk    (clk),
        .rst_n  (rst_n),
        .stream (stream),
        .take   (take),
        .stage  (stage)
    );

    cfpp_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .stage  (stage),
        .take   (take),
        .report (report)
    );

endmodule

`default_nettype wire
